FILE: design/slmms_pkg.sv
// slmms_pkg: shared types, field widths and codes of the sparse linear scorer.
// No dependencies; imported by every other file of the block but slmms_ram.
`default_nettype none

package slmms_pkg;

    localparam int DEF_MAX_MODELS = 4;
    localparam int DEF_MAX_DIMS   = 4096;

    localparam int MODE_W  = 2;
    localparam int SEL_W   = 2;
    localparam int IDX_W   = 13;
    localparam int VAL_W   = 32;
    localparam int LBL_W   = 16;
    localparam int MCNT_W  = 3;
    localparam int DIMS_W  = 13;
    localparam int ACC_W   = 64;
    localparam int RND_W   = 48;
    localparam int CIDX_W  = 2;
    localparam int CDAT_W  = 13;

    // config register indexes
    localparam logic [CIDX_W-1:0] CFG_MODELS = 2'd0;
    localparam logic [CIDX_W-1:0] CFG_DIMS   = 2'd1;

    typedef enum logic [MODE_W-1:0] {
        MODE_WEIGHT = 2'd0,
        MODE_BIAS   = 2'd1,
        MODE_FEAT   = 2'd2,
        MODE_NONE   = 2'd3
    } t_mode;

    // token handed from cell to cell; vld set only for an operation that takes effect
    typedef struct packed {
        logic                    vld;
        t_mode                   op;
        logic [SEL_W-1:0]        sel;
        logic [IDX_W-1:0]        idx;
        logic signed [VAL_W-1:0] val;
    } t_tok;

    typedef struct packed {
        logic capture;  // latch saturated score, clear accumulator
        logic shift;    // move scores one cell toward the head
    } t_ctl;

endpackage

`default_nettype wire

FILE: design/slmms_if.sv
// slmms_if: valid/ready channel interfaces (config, input item, result item).
// Depends on slmms_pkg for field widths.
`default_nettype none

interface slmms_cfg_if
    import slmms_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [CIDX_W-1:0] index;
    logic [CDAT_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

interface slmms_in_if
    import slmms_pkg::*;
();
    logic                    valid;
    logic                    ready;
    logic [MODE_W-1:0]       mode;
    logic [SEL_W-1:0]        model_sel;
    logic [IDX_W-1:0]        feature_index;
    logic signed [VAL_W-1:0] value;
    logic signed [LBL_W-1:0] label;
    logic                    last_feature;

    modport source (output valid, mode, model_sel, feature_index, value, label, last_feature,
                    input ready);
    modport sink   (input valid, mode, model_sel, feature_index, value, label, last_feature,
                    output ready);
endinterface

interface slmms_out_if
    import slmms_pkg::*;
();
    logic                    valid;
    logic                    ready;
    logic [SEL_W-1:0]        model_out;
    logic signed [VAL_W-1:0] score;
    logic signed [LBL_W-1:0] label_out;
    logic                    index_error;
    logic                    last_score;

    modport source (output valid, model_out, score, label_out, index_error, last_score,
                    input ready);
    modport sink   (input valid, model_out, score, label_out, index_error, last_score,
                    output ready);
endinterface

`default_nettype wire

FILE: design/slmms_ram.sv
// slmms_ram: generic simple dual-port RAM, one write and one registered read per cycle.
// No dependencies.
`default_nettype none

module slmms_ram #(
    parameter int W = 32,
    parameter int D = 4096
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_we,
    input  wire logic [$clog2(D)-1:0] i_waddr,
    input  wire logic [W-1:0]         i_wdata,
    input  wire logic [$clog2(D)-1:0] i_raddr,
    output logic      [W-1:0]         o_rdata
);

    logic [W-1:0] r_mem [D];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

FILE: design/slmms_cell.sv
// slmms_cell: one model of the chain: weight RAM slice, bias, 4-stage MAC, score slot.
// Depends on slmms_pkg and slmms_ram.
`default_nettype none

module slmms_cell
    import slmms_pkg::*;
#(
    parameter int ID       = 0,
    parameter int MAX_DIMS = DEF_MAX_DIMS
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire t_tok                    i_tok,
    output t_tok                         o_tok,
    input  wire logic                    i_en,
    input  wire t_ctl                    i_ctl,
    input  wire logic signed [VAL_W-1:0] i_score_next,
    output logic signed [VAL_W-1:0]      o_score
);

    localparam int AW = $clog2(MAX_DIMS);

    t_tok                    r_tok;
    logic                    r_mac1, r_mac2, r_mac3;
    logic signed [VAL_W-1:0] r_val1;
    logic signed [ACC_W-1:0] r_prod;
    logic signed [RND_W-1:0] r_rnd;
    logic signed [ACC_W-1:0] r_acc;
    logic signed [VAL_W-1:0] r_bias;
    logic signed [VAL_W-1:0] r_score;

    logic                    w_mine, w_we, w_feat;
    logic [IDX_W-1:0]        w_idx_m1;
    logic [AW-1:0]           w_addr;
    logic [VAL_W-1:0]        w_rd;
    logic signed [ACC_W-1:0] w_prod, w_rsum;
    logic signed [ACC_W:0]   w_asum, w_ssum;
    logic signed [ACC_W-1:0] w_acc_sat;
    logic signed [VAL_W-1:0] w_score_sat;

    assign w_mine   = (32'(i_tok.sel) == ID);
    assign w_we     = i_tok.vld && (i_tok.op == MODE_WEIGHT) && w_mine;
    assign w_feat   = i_tok.vld && (i_tok.op == MODE_FEAT) && i_en;
    assign w_idx_m1 = i_tok.idx - IDX_W'(1);
    assign w_addr   = AW'(w_idx_m1);

    slmms_ram #(.W(VAL_W), .D(MAX_DIMS)) u_wram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_addr),
        .i_wdata (i_tok.val),
        .i_raddr (w_addr),
        .o_rdata (w_rd)
    );

    // exact Q32.32 product, then floor((p + 2^15) / 2^16)
    assign w_prod = $signed(w_rd) * r_val1;
    assign w_rsum = r_prod + 64'sd32768;

    // saturating accumulate at 64 bits
    assign w_asum = {r_acc[ACC_W-1], r_acc} + (ACC_W+1)'(r_rnd);
    always_comb begin
        if (w_asum[ACC_W] != w_asum[ACC_W-1]) begin
            w_acc_sat = w_asum[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
        end else begin
            w_acc_sat = w_asum[ACC_W-1:0];
        end
    end

    // score: accumulator plus bias, clamped to Q16.16
    assign w_ssum = {r_acc[ACC_W-1], r_acc} + (ACC_W+1)'(r_bias);
    always_comb begin
        if (w_ssum[ACC_W:VAL_W-1] == '0 || w_ssum[ACC_W:VAL_W-1] == '1) begin
            w_score_sat = w_ssum[VAL_W-1:0];
        end else if (w_ssum[ACC_W]) begin
            w_score_sat = {1'b1, {(VAL_W-1){1'b0}}};
        end else begin
            w_score_sat = {1'b0, {(VAL_W-1){1'b1}}};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok.vld <= 1'b0;
            r_mac1    <= 1'b0;
            r_mac2    <= 1'b0;
            r_mac3    <= 1'b0;
            r_acc     <= '0;
            r_bias    <= '0;
        end else begin
            r_tok  <= i_tok;
            r_mac1 <= w_feat;
            r_mac2 <= r_mac1;
            r_mac3 <= r_mac2;
            if (i_tok.vld && (i_tok.op == MODE_BIAS) && w_mine) begin
                r_bias <= i_tok.val;
            end
            if (i_ctl.capture) begin
                r_acc <= '0;
            end else if (r_mac3) begin
                r_acc <= w_acc_sat;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_val1 <= i_tok.val;
        r_prod <= w_prod;
        r_rnd  <= w_rsum[ACC_W-1:16];
        if (i_ctl.capture) begin
            r_score <= w_score_sat;
        end else if (i_ctl.shift) begin
            r_score <= i_score_next;
        end
    end

    assign o_tok   = r_tok;
    assign o_score = r_score;

endmodule

`default_nettype wire

FILE: design/sparse_linear_multi_model_scorer.sv
// sparse_linear_multi_model_scorer: top level, sequencer and chain of model cells.
// Depends on slmms_pkg, slmms_if, slmms_cell (and slmms_ram below it).
//
// Usage:
//   i_cfg  - register writes (index 0: models in use, index 1: dims in use); always ready.
//   i_in   - one transaction per item: mode 0 loads a weight, mode 1 a bias, mode 2 is a
//            feature of an example, mode 3 is dropped. Ready only while the block is idle.
//   o_out  - after the item flagged last_feature, one transaction per model in use,
//            model 0 first, last_score on the final one.
// Each item token walks down the chain, one cell per cycle; cell k owns model k's weight
// RAM, bias and accumulator and runs read, multiply, round and accumulate in that order.
// An accepted load or feature item holds i_in.ready low through the run state, whose
// length is set by the chain length plus the MAC depth. On a last item the scores are
// latched at the end of the run state and shifted out of cell 0, one per cycle while
// o_out.ready is high; a stalled receiver simply holds the current score, and no new
// item is taken until the final score is delivered.
// Dropped mode-3 items leave the block idle and ready. Reset (i_rst_n low, synchronous)
// clears the biases, accumulators, error flag and registers to their defaults; weights
// stay undefined until loaded. No clearing pass is needed.
`default_nettype none

module sparse_linear_multi_model_scorer
    import slmms_pkg::*;
#(
    parameter int MAX_MODELS = DEF_MAX_MODELS,
    parameter int MAX_DIMS   = DEF_MAX_DIMS
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    slmms_cfg_if.sink  i_cfg,
    slmms_in_if.sink   i_in,
    slmms_out_if.source o_out
);

    localparam int CAP     = (MAX_MODELS < 4) ? MAX_MODELS : 4;
    localparam int RUN_END = MAX_MODELS + 3;
    localparam int CNT_W   = $clog2(MAX_MODELS + 4);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_RUN  = 3'b010,
        ST_OUT  = 3'b100
    } t_state;

    t_state                  r_state;
    logic [CNT_W-1:0]        r_cnt;
    logic [SEL_W-1:0]        r_ocnt;
    logic [MCNT_W-1:0]       r_models;
    logic [DIMS_W-1:0]       r_dims;
    t_tok                    r_tok;
    logic signed [LBL_W-1:0] r_label;
    logic                    r_err;
    logic                    r_last;

    t_tok                    n_tok;
    t_mode                   w_mode;
    logic                    w_acc_in, w_acc_out, w_idx_ok, w_load_ok;
    logic [MCNT_W-1:0]       w_neff;
    logic                    w_last_score;
    t_ctl                    w_ctl;
    logic [MAX_MODELS-1:0]   w_en;
    t_tok                    w_tok   [MAX_MODELS+1];
    logic signed [VAL_W-1:0] w_score [MAX_MODELS+1];

    assign w_mode    = t_mode'(i_in.mode);
    assign w_acc_in  = i_in.valid && i_in.ready;
    assign w_acc_out = o_out.valid && o_out.ready;

    // effective model count: 0 acts as 1, capped at min(MAX_MODELS, 4)
    always_comb begin
        if (r_models == '0) begin
            w_neff = MCNT_W'(1);
        end else if (32'(r_models) > CAP) begin
            w_neff = MCNT_W'(CAP);
        end else begin
            w_neff = r_models;
        end
    end

    // feature index valid when 1 <= idx <= min(dims_in_use, MAX_DIMS)
    assign w_idx_ok  = (i_in.feature_index != '0)
                    && (i_in.feature_index <= r_dims)
                    && (32'(i_in.feature_index) <= MAX_DIMS);
    assign w_load_ok = (32'(i_in.model_sel) < MAX_MODELS)
                    && (i_in.feature_index != '0)
                    && (32'(i_in.feature_index) <= MAX_DIMS);

    always_comb begin
        n_tok.op  = w_mode;
        n_tok.sel = i_in.model_sel;
        n_tok.idx = i_in.feature_index;
        n_tok.val = i_in.value;
        case (w_mode)
            MODE_WEIGHT: n_tok.vld = w_load_ok;
            MODE_BIAS:   n_tok.vld = (32'(i_in.model_sel) < MAX_MODELS);
            MODE_FEAT:   n_tok.vld = w_idx_ok;
            default:     n_tok.vld = 1'b0;
        endcase
    end

    assign w_last_score  = ({1'b0, r_ocnt} + MCNT_W'(1)) == w_neff;
    assign w_ctl.capture = (r_state == ST_RUN) && (r_cnt == CNT_W'(RUN_END)) && r_last;
    assign w_ctl.shift   = w_acc_out;

    // config port
    assign i_cfg.ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_models <= MCNT_W'(4);
            r_dims   <= DIMS_W'(4096);
        end else if (i_cfg.valid && i_cfg.ready) begin
            case (i_cfg.index)
                CFG_MODELS: r_models <= i_cfg.data[MCNT_W-1:0];
                CFG_DIMS:   r_dims   <= i_cfg.data[DIMS_W-1:0];
                default:    ;
            endcase
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_cnt     <= '0;
            r_ocnt    <= '0;
            r_err     <= 1'b0;
            r_last    <= 1'b0;
            r_tok.vld <= 1'b0;
        end else begin
            // token is live for exactly one cycle after an accepted item that takes effect
            r_tok.vld <= w_acc_in && n_tok.vld;
            case (r_state)
                ST_IDLE: begin
                    if (w_acc_in && (w_mode != MODE_NONE)) begin
                        r_tok.op  <= n_tok.op;
                        r_tok.sel <= n_tok.sel;
                        r_tok.idx <= n_tok.idx;
                        r_tok.val <= n_tok.val;
                        r_cnt     <= '0;
                        r_last    <= (w_mode == MODE_FEAT) && i_in.last_feature;
                        r_state   <= ST_RUN;
                        if (w_mode == MODE_FEAT) begin
                            r_label <= i_in.label;
                            if (!w_idx_ok) begin
                                r_err <= 1'b1;
                            end
                        end
                    end
                end
                ST_RUN: begin
                    if (r_cnt == CNT_W'(RUN_END)) begin
                        r_ocnt  <= '0;
                        r_state <= r_last ? ST_OUT : ST_IDLE;
                    end else begin
                        r_cnt <= r_cnt + CNT_W'(1);
                    end
                end
                ST_OUT: begin
                    if (w_acc_out) begin
                        if (w_last_score) begin
                            r_err   <= 1'b0;
                            r_state <= ST_IDLE;
                        end else begin
                            r_ocnt <= r_ocnt + SEL_W'(1);
                        end
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign i_in.ready = (r_state == ST_IDLE);

    // chain of model cells
    assign w_tok[0]            = r_tok;
    assign w_score[MAX_MODELS] = '0;

    for (genvar k = 0; k < MAX_MODELS; k++) begin : g_cell
        assign w_en[k] = (k < int'(w_neff));
        slmms_cell #(.ID(k), .MAX_DIMS(MAX_DIMS)) u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_tok        (w_tok[k]),
            .o_tok        (w_tok[k+1]),
            .i_en         (w_en[k]),
            .i_ctl        (w_ctl),
            .i_score_next (w_score[k+1]),
            .o_score      (w_score[k])
        );
    end

    assign o_out.valid       = (r_state == ST_OUT);
    assign o_out.model_out   = r_ocnt;
    assign o_out.score       = w_score[0];
    assign o_out.label_out   = r_label;
    assign o_out.index_error = r_err;
    assign o_out.last_score  = w_last_score;

    // results and new items never overlap
    a_out_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> !i_in.ready)
        else $error("result offered while input is open");

    // a capture starts the result burst at model 0
    a_cap_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctl.capture |=> (o_out.valid && (o_out.model_out == '0)))
        else $error("capture did not start a burst at model 0");

    // the final result returns to idle with the error flag cleared
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc_out && o_out.last_score) |=> (i_in.ready && !o_out.index_error))
        else $error("burst end did not return to idle");

    // model number stays within the models in use
    a_ocnt_rng: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> ({1'b0, o_out.model_out} < w_neff))
        else $error("model number beyond models in use");

endmodule

`default_nettype wire
